FILE: rtl/sdjs_pkg.sv
// shared types, constants and codes for the stretch-deadline job scheduler
package sdjs_pkg;

  // sizing defaults
  localparam int unsigned QUEUE_DEPTH_DEF = 64;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned FIFO_DEPTH      = 2;

  // fixed field widths
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned TIME_W    = 32;
  localparam int unsigned SPEED_W   = 16;
  localparam int unsigned STRETCH_W = 16;
  localparam int unsigned PROD_W    = TIME_W + STRETCH_W;
  localparam int unsigned RANK_W    = 42;
  localparam int unsigned TAKE_W    = PROD_W - 8;
  localparam int unsigned STATUS_W  = 3;

  // register map
  localparam logic [2:0] ADDR_STRETCH = 3'd0;
  localparam logic [STRETCH_W-1:0] STRETCH_RESET = 16'd256;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ARRIVE = 2'd0,
    FUNC_DEPART = 2'd1,
    FUNC_RUN    = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EMPTY     = 3'd1,
    ST_NOT_TOP   = 3'd2,
    ST_FULL      = 3'd3,
    ST_OVERRUN   = 3'd4,
    ST_WORK_LEFT = 3'd5
  } status_e;

  // queue handshake between front and back
  typedef struct packed {
    logic valid;
    logic stall;
  } hs_t;

endpackage

FILE: rtl/sdjs_front.sv
// front end: accepts beats, forms rank and run takeout
module sdjs_front #(
  parameter int unsigned ID_BITS = sdjs_pkg::ID_BITS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [sdjs_pkg::FUNC_W-1:0]      func_i,
  input  logic [ID_BITS-1:0]               job_id_i,
  input  logic [sdjs_pkg::TIME_W-1:0]      arrival_time_i,
  input  logic [sdjs_pkg::TIME_W-1:0]      job_size_i,
  input  logic [sdjs_pkg::TIME_W-1:0]      elapsed_i,
  input  logic [sdjs_pkg::SPEED_W-1:0]     speed_i,
  input  logic [sdjs_pkg::STRETCH_W-1:0]   stretch_i,
  output sdjs_pkg::hs_t                    cmd_hs_o,
  input  logic                             cmd_stall_i,
  output logic [sdjs_pkg::FUNC_W-1:0]      cmd_func_o,
  output logic [ID_BITS-1:0]               cmd_id_o,
  output logic [sdjs_pkg::RANK_W-1:0]      cmd_rank_o,
  output logic [sdjs_pkg::TIME_W-1:0]      cmd_size_o,
  output logic [sdjs_pkg::TAKE_W-1:0]      cmd_take_o
);

  // stage one: captured beat
  logic                           v1_q;
  logic [sdjs_pkg::FUNC_W-1:0]    func1_q;
  logic [ID_BITS-1:0]             id1_q;
  logic [sdjs_pkg::TIME_W-1:0]    arr1_q, size1_q, elap1_q;
  logic [sdjs_pkg::SPEED_W-1:0]   speed1_q;
  logic [sdjs_pkg::STRETCH_W-1:0] str1_q;

  // stage two: registered products
  logic                           v2_q;
  logic [sdjs_pkg::FUNC_W-1:0]    func2_q;
  logic [ID_BITS-1:0]             id2_q;
  logic [sdjs_pkg::TIME_W-1:0]    arr2_q, size2_q;
  logic [sdjs_pkg::PROD_W-1:0]    rprod2_q, tprod2_q;

  logic s2_free, s1_free, take_in;

  assign s2_free    = !v2_q || !cmd_stall_i;
  assign s1_free    = !v1_q || s2_free;
  assign in_stall_o = !s1_free;
  assign take_in    = in_valid_i && s1_free;

  // valid pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s1_free) v1_q <= in_valid_i;
      if (s2_free) v2_q <= v1_q;
    end
  end

  // payload capture, stretch sampled with the beat
  always_ff @(posedge clk_i) begin
    if (take_in) begin
      func1_q  <= func_i;
      id1_q    <= job_id_i;
      arr1_q   <= arrival_time_i;
      size1_q  <= job_size_i;
      elap1_q  <= elapsed_i;
      speed1_q <= speed_i;
      str1_q   <= stretch_i;
    end
    if (s2_free && v1_q) begin
      func2_q  <= func1_q;
      id2_q    <= id1_q;
      arr2_q   <= arr1_q;
      size2_q  <= size1_q;
      rprod2_q <= size1_q * str1_q;
      tprod2_q <= elap1_q * speed1_q;
    end
  end

  // rank sum and takeout toward the queue
  assign cmd_hs_o.valid = v2_q;
  assign cmd_hs_o.stall = cmd_stall_i;
  assign cmd_func_o = func2_q;
  assign cmd_id_o   = id2_q;
  assign cmd_size_o = size2_q;
  assign cmd_rank_o = {{(sdjs_pkg::RANK_W-sdjs_pkg::TIME_W){1'b0}}, arr2_q}
                    + {{(sdjs_pkg::RANK_W-sdjs_pkg::TAKE_W){1'b0}},
                       rprod2_q[sdjs_pkg::PROD_W-1:8]};
  assign cmd_take_o = tprod2_q[sdjs_pkg::PROD_W-1:8];

endmodule

FILE: rtl/sdjs_fifo.sv
// short command queue between front and back
module sdjs_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_stall_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_stall_i,
  output logic [WIDTH-1:0] pop_data_o
);

  localparam int unsigned PTR_W = $clog2(sdjs_pkg::FIFO_DEPTH);
  localparam int unsigned CNT_W = $clog2(sdjs_pkg::FIFO_DEPTH + 1);

  logic [WIDTH-1:0] mem_q [sdjs_pkg::FIFO_DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic push, pop;

  assign push_stall_o = (cnt_q == CNT_W'(sdjs_pkg::FIFO_DEPTH));
  assign pop_valid_o  = (cnt_q != '0);
  assign push = push_valid_i && !push_stall_o;
  assign pop  = pop_valid_o && !pop_stall_i;
  assign pop_data_o = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PTR_W'(sdjs_pkg::FIFO_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PTR_W'(sdjs_pkg::FIFO_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= push_data_i;
  end

endmodule

FILE: rtl/sdjs_back.sv
// back end: sorted row of job cells and the result register
module sdjs_back #(
  parameter int unsigned QUEUE_DEPTH = sdjs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = sdjs_pkg::ID_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sdjs_pkg::hs_t                  cmd_hs_i,
  output logic                           cmd_stall_o,
  input  logic [sdjs_pkg::FUNC_W-1:0]    cmd_func_i,
  input  logic [ID_BITS-1:0]             cmd_id_i,
  input  logic [sdjs_pkg::RANK_W-1:0]    cmd_rank_i,
  input  logic [sdjs_pkg::TIME_W-1:0]    cmd_size_i,
  input  logic [sdjs_pkg::TAKE_W-1:0]    cmd_take_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sdjs_pkg::STATUS_W-1:0]  status_o,
  output logic                           preempted_o,
  output logic [ID_BITS-1:0]             removed_id_o,
  output logic                           top_valid_o,
  output logic [ID_BITS-1:0]             top_id_o,
  output logic [sdjs_pkg::TIME_W-1:0]    top_remaining_o,
  output logic [CNT_W-1:0]               queue_count_o
);

  // cells kept sorted by rank, earlier entry first among equals
  logic [sdjs_pkg::RANK_W-1:0] rank_q [QUEUE_DEPTH];
  logic [ID_BITS-1:0]          id_q   [QUEUE_DEPTH];
  logic [sdjs_pkg::TIME_W-1:0] rem_q  [QUEUE_DEPTH];
  logic [sdjs_pkg::RANK_W-1:0] rank_d [QUEUE_DEPTH];
  logic [ID_BITS-1:0]          id_d   [QUEUE_DEPTH];
  logic [sdjs_pkg::TIME_W-1:0] rem_d  [QUEUE_DEPTH];
  logic [CNT_W-1:0]            count_q, count_d;
  logic [QUEUE_DEPTH-1:0]      keep;

  logic                          ov_q;
  logic [sdjs_pkg::STATUS_W-1:0] status_q, status_d;
  logic                          pre_q, pre_d;
  logic [ID_BITS-1:0]            rem_id_q, rem_id_d;
  logic                          tv_q;
  logic [ID_BITS-1:0]            tid_q;
  logic [sdjs_pkg::TIME_W-1:0]   trem_q;
  logic [CNT_W-1:0]              qc_q;
  logic                          exec;

  assign exec        = cmd_hs_i.valid && (!ov_q || !out_stall_i);
  assign cmd_stall_o = !exec;

  // cells that stay ahead of an arriving job
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      keep[i] = (CNT_W'(i) < count_q) && (rank_q[i] <= cmd_rank_i);
    end
  end

  // step of the cell row
  always_comb begin
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      rank_d[i] = rank_q[i];
      id_d[i]   = id_q[i];
      rem_d[i]  = rem_q[i];
    end
    count_d  = count_q;
    status_d = sdjs_pkg::ST_OK;
    pre_d    = 1'b0;
    rem_id_d = '0;
    unique case (sdjs_pkg::func_e'(cmd_func_i))
      sdjs_pkg::FUNC_ARRIVE: begin
        if (count_q == CNT_W'(QUEUE_DEPTH)) begin
          status_d = sdjs_pkg::ST_FULL;
        end else begin
          pre_d   = !keep[0];
          count_d = count_q + 1'b1;
          for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (!keep[i]) begin
              if (i == 0 || keep[(i == 0) ? 0 : i-1]) begin
                rank_d[i] = cmd_rank_i;
                id_d[i]   = cmd_id_i;
                rem_d[i]  = cmd_size_i;
              end else begin
                rank_d[i] = rank_q[(i == 0) ? 0 : i-1];
                id_d[i]   = id_q[(i == 0) ? 0 : i-1];
                rem_d[i]  = rem_q[(i == 0) ? 0 : i-1];
              end
            end
          end
        end
      end
      sdjs_pkg::FUNC_DEPART: begin
        if (count_q == '0) begin
          status_d = sdjs_pkg::ST_EMPTY;
        end else if (id_q[0] != cmd_id_i) begin
          status_d = sdjs_pkg::ST_NOT_TOP;
        end else begin
          status_d = (rem_q[0] != '0) ? sdjs_pkg::ST_WORK_LEFT : sdjs_pkg::ST_OK;
          rem_id_d = id_q[0];
          count_d  = count_q - 1'b1;
          for (int i = 0; i < QUEUE_DEPTH - 1; i++) begin
            rank_d[i] = rank_q[i+1];
            id_d[i]   = id_q[i+1];
            rem_d[i]  = rem_q[i+1];
          end
        end
      end
      sdjs_pkg::FUNC_RUN: begin
        if (count_q != '0) begin
          if (cmd_take_i > {{(sdjs_pkg::TAKE_W-sdjs_pkg::TIME_W){1'b0}}, rem_q[0]}) begin
            rem_d[0] = '0;
            status_d = sdjs_pkg::ST_OVERRUN;
          end else begin
            rem_d[0] = rem_q[0] - cmd_take_i[sdjs_pkg::TIME_W-1:0];
          end
        end
      end
      default: ;
    endcase
  end

  // job count and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      if (exec) count_q <= count_d;
      ov_q <= exec || (ov_q && out_stall_i);
    end
  end

  // cell contents and result payload
  always_ff @(posedge clk_i) begin
    if (exec) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
        rank_q[i] <= rank_d[i];
        id_q[i]   <= id_d[i];
        rem_q[i]  <= rem_d[i];
      end
      status_q <= status_d;
      pre_q    <= pre_d;
      rem_id_q <= rem_id_d;
      tv_q     <= (count_d != '0);
      tid_q    <= (count_d != '0) ? id_d[0] : '0;
      trem_q   <= (count_d != '0) ? rem_d[0] : '0;
      qc_q     <= count_d;
    end
  end

  assign out_valid_o     = ov_q;
  assign status_o        = status_q;
  assign preempted_o     = pre_q;
  assign removed_id_o    = rem_id_q;
  assign top_valid_o     = tv_q;
  assign top_id_o        = tid_q;
  assign top_remaining_o = trem_q;
  assign queue_count_o   = qc_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(QUEUE_DEPTH)) else $error("job count over depth");

  a_count_still: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !exec |=> $stable(count_q)) else $error("job count moved without a command");

  a_top_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q |-> (tv_q == (qc_q != '0))) else $error("top flag disagrees with count");

  a_full_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && (status_d == sdjs_pkg::ST_FULL) |=> $stable(count_q))
    else $error("full arrival changed the count");

endmodule

FILE: rtl/stretch_deadline_job_scheduler_top.sv
// top level of the stretch-deadline job scheduler
// Earliest-rank-first preemptive scheduler. A beat enters a two-stage front end
// that forms the rank (arrival time plus size times stretch) and the run takeout
// (elapsed times speed) with one registered multiply each, passes a two-entry
// command queue, and is applied to a row of sorted job cells whose first cell
// is always the executing job. One beat can enter every cycle while the output
// is not stalled; each command updates the full cell row combinationally, which
// sets the back end's pace. The stretch register lives at byte address 0; the
// user must write it only while idle, and the block does not enforce this.
module stretch_deadline_job_scheduler_top #(
  parameter int unsigned QUEUE_DEPTH = sdjs_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned ID_BITS     = sdjs_pkg::ID_BITS_DEF,
  localparam int unsigned CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [2:0]                     paddr,
  input  logic [31:0]                    pwdata,
  output logic [31:0]                    prdata,
  output logic                           pready,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [sdjs_pkg::FUNC_W-1:0]    func_i,
  input  logic [ID_BITS-1:0]             job_id_i,
  input  logic [sdjs_pkg::TIME_W-1:0]    arrival_time_i,
  input  logic [sdjs_pkg::TIME_W-1:0]    job_size_i,
  input  logic [sdjs_pkg::TIME_W-1:0]    elapsed_i,
  input  logic [sdjs_pkg::SPEED_W-1:0]   speed_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [sdjs_pkg::STATUS_W-1:0]  status_o,
  output logic                           preempted_o,
  output logic [ID_BITS-1:0]             removed_id_o,
  output logic                           top_valid_o,
  output logic [ID_BITS-1:0]             top_id_o,
  output logic [sdjs_pkg::TIME_W-1:0]    top_remaining_o,
  output logic [CNT_W-1:0]               queue_count_o
);

  localparam int unsigned CMD_W = sdjs_pkg::FUNC_W + ID_BITS + sdjs_pkg::RANK_W
                                + sdjs_pkg::TIME_W + sdjs_pkg::TAKE_W;

  logic [sdjs_pkg::STRETCH_W-1:0] stretch_q;
  sdjs_pkg::hs_t                  f_hs, b_hs;
  logic                           f_stall, b_stall;
  logic [sdjs_pkg::FUNC_W-1:0]    f_func, b_func;
  logic [ID_BITS-1:0]             f_id, b_id;
  logic [sdjs_pkg::RANK_W-1:0]    f_rank, b_rank;
  logic [sdjs_pkg::TIME_W-1:0]    f_size, b_size;
  logic [sdjs_pkg::TAKE_W-1:0]    f_take, b_take;
  logic [CMD_W-1:0]               q_in, q_out;
  logic                           q_valid;

  // configuration register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == sdjs_pkg::ADDR_STRETCH[2])
                ? {{(32-sdjs_pkg::STRETCH_W){1'b0}}, stretch_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stretch_q <= sdjs_pkg::STRETCH_RESET;
    end else if (psel && penable && pwrite && pready
                 && paddr[2] == sdjs_pkg::ADDR_STRETCH[2]) begin
      stretch_q <= pwdata[sdjs_pkg::STRETCH_W-1:0];
    end
  end

  sdjs_front #(.ID_BITS(ID_BITS)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .func_i, .job_id_i,
    .arrival_time_i, .job_size_i, .elapsed_i, .speed_i,
    .stretch_i(stretch_q), .cmd_hs_o(f_hs), .cmd_stall_i(f_stall),
    .cmd_func_o(f_func), .cmd_id_o(f_id), .cmd_rank_o(f_rank),
    .cmd_size_o(f_size), .cmd_take_o(f_take)
  );

  // command queue
  assign q_in = {f_func, f_id, f_rank, f_size, f_take};
  assign {b_func, b_id, b_rank, b_size, b_take} = q_out;

  sdjs_fifo #(.WIDTH(CMD_W)) u_fifo (
    .clk_i, .rst_ni, .push_valid_i(f_hs.valid), .push_stall_o(f_stall),
    .push_data_i(q_in), .pop_valid_o(q_valid), .pop_stall_i(b_stall),
    .pop_data_o(q_out)
  );

  assign b_hs.valid = q_valid;
  assign b_hs.stall = b_stall;

  sdjs_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .ID_BITS(ID_BITS)) u_back (
    .clk_i, .rst_ni, .cmd_hs_i(b_hs), .cmd_stall_o(b_stall),
    .cmd_func_i(b_func), .cmd_id_i(b_id), .cmd_rank_i(b_rank),
    .cmd_size_i(b_size), .cmd_take_i(b_take), .out_valid_o, .out_stall_i,
    .status_o, .preempted_o, .removed_id_o, .top_valid_o, .top_id_o,
    .top_remaining_o, .queue_count_o
  );

endmodule

FILE: tb/testbench.sv
// self-checking testbench for the stretch-deadline job scheduler top level
`timescale 1ns / 100ps

module testbench;

  localparam int unsigned DEPTH = 64;
  localparam int unsigned LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [2:0]  status;
    logic        preempted;
    logic [15:0] removed_id;
    logic        top_valid;
    logic [15:0] top_id;
    logic [31:0] top_remaining;
    logic [6:0]  queue_count;
  } sched_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [1:0] func_i = '0;
  logic [15:0] job_id_i = '0;
  logic [31:0] arrival_time_i = '0, job_size_i = '0, elapsed_i = '0;
  logic [15:0] speed_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b1;
  logic [2:0] status_o;
  logic preempted_o;
  logic [15:0] removed_id_o, top_id_o;
  logic top_valid_o;
  logic [31:0] top_remaining_o;
  logic [6:0] queue_count_o;

  stretch_deadline_job_scheduler_top i_dut (.*);

  // shadow job list, kept in order of entry
  logic [41:0] job_rank [DEPTH];
  logic [15:0] job_ident [DEPTH];
  logic [31:0] job_work [DEPTH];
  int unsigned jobs_held;
  logic [15:0] stretch_q = sdjs_pkg::STRETCH_RESET;

  sched_result_t expected_results[$];
  int unsigned mismatch_cnt, beats_sent, results_seen, cycle_cnt;
  bit hold_off;

  initial forever #2 clk_i = ~clk_i;

  // timeout watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > LIMIT_CYCLES) begin
      $display("stretch_deadline_job_scheduler_top test failed");
      $finish;
    end
  end

  function automatic int unsigned top_index();
    int unsigned best;
    best = 0;
    for (int unsigned k = 1; k < jobs_held; k++)
      if (job_rank[k] < job_rank[best]) best = k;
    return best;
  endfunction

  // apply one beat to the shadow list and return the result it must produce
  function automatic sched_result_t schedule_step(sdjs_pkg::func_e fn, logic [15:0] id,
      logic [31:0] arr, logic [31:0] size, logic [31:0] el, logic [15:0] spd);
    sched_result_t r;
    logic [47:0] prod;
    logic [41:0] rank;
    logic [39:0] takeout;
    int unsigned t;
    r = '0;
    case (fn)
      sdjs_pkg::FUNC_ARRIVE: begin
        if (jobs_held >= DEPTH) r.status = sdjs_pkg::ST_FULL;
        else begin
          prod = size * stretch_q;
          rank = {10'd0, arr} + {2'd0, prod[47:8]};
          if (jobs_held == 0 || rank < job_rank[top_index()]) r.preempted = 1'b1;
          job_rank[jobs_held] = rank;
          job_ident[jobs_held] = id;
          job_work[jobs_held] = size;
          jobs_held++;
        end
      end
      sdjs_pkg::FUNC_DEPART: begin
        if (jobs_held == 0) r.status = sdjs_pkg::ST_EMPTY;
        else begin
          t = top_index();
          if (job_ident[t] != id) r.status = sdjs_pkg::ST_NOT_TOP;
          else begin
            r.status = (job_work[t] != 0) ? sdjs_pkg::ST_WORK_LEFT : sdjs_pkg::ST_OK;
            r.removed_id = job_ident[t];
            for (int unsigned k = t; k + 1 < jobs_held; k++) begin
              job_rank[k] = job_rank[k+1];
              job_ident[k] = job_ident[k+1];
              job_work[k] = job_work[k+1];
            end
            jobs_held--;
          end
        end
      end
      sdjs_pkg::FUNC_RUN: begin
        if (jobs_held > 0) begin
          prod = el * spd;
          takeout = prod[47:8];
          t = top_index();
          if (takeout > {8'd0, job_work[t]}) begin
            job_work[t] = '0;
            r.status = sdjs_pkg::ST_OVERRUN;
          end else job_work[t] = job_work[t] - takeout[31:0];
        end
      end
      default: ;
    endcase
    if (jobs_held > 0) begin
      t = top_index();
      r.top_valid = 1'b1;
      r.top_id = job_ident[t];
      r.top_remaining = job_work[t];
    end
    r.queue_count = jobs_held[6:0];
    return r;
  endfunction

  // random gap, mostly short, sometimes long
  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(3);
    return $urandom_range(40, 8);
  endfunction

  // send one beat and record its expectation; valid stays up for a following beat
  task automatic send_beat(sdjs_pkg::func_e fn, logic [15:0] id, logic [31:0] arr,
      logic [31:0] size, logic [31:0] el, logic [15:0] spd, bit may_gap = 1);
    int unsigned g;
    g = may_gap ? pick_gap() : 0;
    if (g > 0) begin
      in_valid_i <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    func_i <= fn;
    job_id_i <= id;
    arrival_time_i <= arr;
    job_size_i <= size;
    elapsed_i <= el;
    speed_i <= spd;
    expected_results.push_back(schedule_step(fn, id, arr, size, el, spd));
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
  endtask

  // result checker and output stall generator
  initial begin
    int unsigned g;
    sched_result_t got, exp_r;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i) begin
        got = {status_o, preempted_o, removed_id_o, top_valid_o, top_id_o,
               top_remaining_o, queue_count_o};
        results_seen++;
        if (expected_results.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("unexpected result beat %p", got);
        end else begin
          exp_r = expected_results.pop_front();
          if (got !== exp_r) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("mismatch at result %0d: expected %p actual %p",
                       results_seen, exp_r, got);
          end
        end
      end
      if (hold_off) out_stall_i <= 1'b1;
      else if (g > 0) begin
        g--;
        out_stall_i <= 1'b1;
      end else begin
        g = ($urandom_range(3) == 0) ? pick_gap() : 0;
        out_stall_i <= (g > 0);
      end
    end
  end

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_stretch(logic [15:0] v);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= sdjs_pkg::ADDR_STRETCH; pwdata <= {16'd0, v};
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    stretch_q = v;
  endtask

  function automatic logic [15:0] rand_id();
    return $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(15));
  endfunction

  // extremes of every field and each status other than full
  task automatic test_directed();
    send_beat(sdjs_pkg::FUNC_DEPART, 16'd0, '0, '0, '0, '0);
    send_beat(sdjs_pkg::FUNC_RUN, 16'd0, '0, '0, '1, '1);
    send_beat(sdjs_pkg::FUNC_NOP, 16'hffff, '1, '1, '1, '1);
    send_beat(sdjs_pkg::FUNC_ARRIVE, 16'hffff, '1, '1, '0, '0);
    send_beat(sdjs_pkg::FUNC_ARRIVE, 16'h0001, 32'd0, 32'd100, '0, '0);
    send_beat(sdjs_pkg::FUNC_ARRIVE, 16'h0002, 32'd0, 32'd100, '0, '0);
    send_beat(sdjs_pkg::FUNC_DEPART, 16'h0002, '0, '0, '0, '0);
    send_beat(sdjs_pkg::FUNC_RUN, 16'd0, '0, '0, 32'd1, 16'd256);
    send_beat(sdjs_pkg::FUNC_DEPART, 16'h0001, '0, '0, '0, '0);
    send_beat(sdjs_pkg::FUNC_RUN, 16'd0, '0, '0, 32'd100, 16'd256);
    send_beat(sdjs_pkg::FUNC_DEPART, 16'h0002, '0, '0, '0, '0);
    send_beat(sdjs_pkg::FUNC_RUN, 16'd0, '0, '0, '1, '1);
    send_beat(sdjs_pkg::FUNC_DEPART, 16'hffff, '0, '0, '0, '0);
    wait_idle();
  endtask

  // fill past capacity while the output is held stalled downstream
  task automatic test_full_queue();
    hold_off = 1'b1;
    fork
      begin
        int unsigned c;
        c = 0;
        while (c < 150) begin @(posedge clk_i); c++; end
        hold_off = 1'b0;
      end
    join_none
    for (int i = 0; i < DEPTH + 3; i++)
      send_beat(sdjs_pkg::FUNC_ARRIVE, rand_id(), $urandom, $urandom_range(2000),
                '0, '0, 0);
    wait_idle();
    while (jobs_held > 0)
      send_beat(sdjs_pkg::FUNC_DEPART, job_ident[top_index()], '0, '0, '0, '0);
    wait_idle();
  endtask

  // random traffic, mostly well formed departures of the top job
  task automatic test_random(int unsigned n, bit wide_vals);
    int unsigned p;
    logic [15:0] id;
    for (int unsigned i = 0; i < n; i++) begin
      p = $urandom_range(99);
      if (p < 38 && jobs_held < DEPTH) begin
        send_beat(sdjs_pkg::FUNC_ARRIVE, rand_id(),
                  wide_vals ? $urandom : $urandom_range(5000),
                  wide_vals ? $urandom : $urandom_range(3000), $urandom,
                  16'($urandom));
      end else if (p < 68) begin
        id = (jobs_held > 0 && $urandom_range(4) != 0) ? job_ident[top_index()] : rand_id();
        send_beat(sdjs_pkg::FUNC_DEPART, id, $urandom, $urandom, $urandom, 16'($urandom));
      end else if (p < 95) begin
        send_beat(sdjs_pkg::FUNC_RUN, rand_id(), $urandom, $urandom,
                  wide_vals ? $urandom : $urandom_range(400), 16'($urandom));
      end else
        send_beat(sdjs_pkg::FUNC_NOP, rand_id(), $urandom, $urandom, $urandom,
                  16'($urandom));
    end
    wait_idle();
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    write_stretch(16'hffff);
    test_full_queue();
    test_random(320, 0);
    write_stretch(16'd0);
    test_random(230, 1);
    write_stretch(16'd256);
    test_random(230, 0);
    write_stretch(16'($urandom_range(65535, 256)));
    test_random(230, 1);
    $display("sent %0d beats, checked %0d results over several stretch settings",
             beats_sent, results_seen);
    $display("covered arrivals, departures, runs, overrun, full queue and stalls");
    if (mismatch_cnt == 0 && expected_results.size() == 0)
      $display("stretch_deadline_job_scheduler_top test passed");
    else
      $display("stretch_deadline_job_scheduler_top test failed");
    $finish;
  end
endmodule
